>>> rtl/core/dtwpe_pkg.sv
// Shared types and constants for the projected-envelope DTW lower bound core.
`timescale 1ns / 1ps
`default_nettype none
package dtwpe_pkg;

   localparam int MAX_WINDOW_DEF = 32;
   localparam int SAMPLE_W       = 32;
   localparam int BOUND_W        = 63;
   localparam int POS_W          = 16;
   localparam int CFG_W_W        = 6;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int STD_W          = 31;
   localparam int DIV_NUM_W      = 49;
   localparam int DIV_CNT_W      = $clog2(DIV_NUM_W);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 2'd1;

   localparam logic [CFG_W_W-1:0] WINDOW_RESET = 6'd4;
   localparam logic [POS_W-1:0]   LENGTH_RESET = 16'd128;
   localparam logic [POS_W-1:0]   LENGTH_MIN   = 16'd8;
   localparam logic [POS_W-1:0]   EDGE_POS     = 16'd3;
   localparam logic [POS_W-1:0]   TAIL_GAP     = 16'd4;

   localparam logic [BOUND_W-1:0] BOUND_MAX = {BOUND_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVU,
      ST_DIVU_WAIT,
      ST_DIVL,
      ST_DIVL_WAIT,
      ST_WRITE,
      ST_SCAN_INIT,
      ST_SCAN_ADDR,
      ST_SCAN_DATA,
      ST_SQ1,
      ST_SQ2,
      ST_SUM,
      ST_ACC,
      ST_EMIT
   } dtwpe_state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_lower;
      logic store_un;
      logic store_ln;
      logic write;
      logic scan_init;
      logic scan_step;
      logic sq1;
      logic sq2;
      logic sum;
      logic acc;
      logic emit;
   } dtwpe_cmd_type;

   typedef struct packed {
      logic skip;
      logic need_norm;
      logic div_done;
      logic emit_any;
      logic scan_last;
      logic rsp_free;
      logic run_done;
      logic last_j;
   } dtwpe_status_type;

endpackage
`default_nettype wire

>>> rtl/core/dtw_projected_envelope_lower_bound_core.sv
// Top level of the projected-envelope DTW lower bound core.
`timescale 1ns / 1ps
`default_nettype none
// One aligned query/candidate sample per req transfer; rsp carries one bound term per
// transfer. Items are taken one at a time. A sample at positions 3..m-4 is projected
// through two normalizing divisions on a shared bit-serial divider; other samples
// skip them. Each term then scans the clamped-sample ring one entry at a time, an
// address step then a data step, over its window (min(j+w,i)-max(j-w,0)+1 entries),
// followed by a square, subtract and accumulate sequence on a single 32x32 multiplier
// and an output step that waits while rsp is stalled. A new sample is taken only
// once the last one and every term that it releases are done.
// Configuration is latched into the run on a sample flagged first; csr_ready is high.
module dtw_projected_envelope_lower_bound_core #(
   parameter int MAX_WINDOW = dtwpe_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_first,
   input  wire logic signed [31:0]                 req_query_sample,
   input  wire logic signed [31:0]                 req_query_upper,
   input  wire logic signed [31:0]                 req_query_lower,
   input  wire logic signed [31:0]                 req_cand_sample,
   input  wire logic signed [31:0]                 req_cand_upper_raw,
   input  wire logic signed [31:0]                 req_cand_lower_raw,
   input  wire logic signed [31:0]                 req_cand_mean,
   input  wire logic [dtwpe_pkg::STD_W-1:0]        req_cand_std,
   input  wire logic [dtwpe_pkg::BOUND_W-1:0]      req_start_bound,
   input  wire logic [dtwpe_pkg::BOUND_W-1:0]      req_abandon_limit,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [dtwpe_pkg::POS_W-1:0]             rsp_position,
   output logic [dtwpe_pkg::BOUND_W-1:0]           rsp_local_term,
   output logic [dtwpe_pkg::BOUND_W-1:0]           rsp_running_bound,
   output logic                                    rsp_abandoned,
   output logic                                    rsp_done_res,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dtwpe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dtwpe_pkg::CSR_DATA_W-1:0]   csr_data
);
   import dtwpe_pkg::*;

   dtwpe_cmd_type    cmd;
   dtwpe_status_type status;

   assign csr_ready = 1'b1;

   dtwpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dtwpe_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_first          (req_first),
      .req_query_sample   (req_query_sample),
      .req_query_upper    (req_query_upper),
      .req_query_lower    (req_query_lower),
      .req_cand_sample    (req_cand_sample),
      .req_cand_upper_raw (req_cand_upper_raw),
      .req_cand_lower_raw (req_cand_lower_raw),
      .req_cand_mean      (req_cand_mean),
      .req_cand_std       (req_cand_std),
      .req_start_bound    (req_start_bound),
      .req_abandon_limit  (req_abandon_limit),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_position       (rsp_position),
      .rsp_local_term     (rsp_local_term),
      .rsp_running_bound  (rsp_running_bound),
      .rsp_abandoned      (rsp_abandoned),
      .rsp_done_res       (rsp_done_res)
   );

   a_abandon_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_abandoned || rsp_done_res))
      else $error("abandoned term not marked as final");

   a_bound_covers_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_running_bound >= rsp_local_term))
      else $error("running bound below its own term");

   a_position_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position >= EDGE_POS))
      else $error("term reported for an edge position");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second sample taken before the first was processed");

endmodule
`default_nettype wire

>>> rtl/core/dtwpe_div.sv
// Restoring divider, one quotient bit per cycle, for envelope normalization.
`timescale 1ns / 1ps
`default_nettype none
module dtwpe_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [dtwpe_pkg::DIV_NUM_W-1:0]      num,
   input  wire logic [dtwpe_pkg::STD_W-1:0]          den,
   output logic                                      done,
   output logic [dtwpe_pkg::DIV_NUM_W-1:0]           quot
);
   import dtwpe_pkg::*;

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [STD_W:0]       rem_ff, rem_in;
   logic [STD_W-1:0]     den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [STD_W:0]       shifted;

   always_comb begin
      shifted = {rem_ff[STD_W-1:0], quot_ff[DIV_NUM_W-1]};
      if (shifted >= {1'b0, den_ff}) begin
         rem_in  = shifted - {1'b0, den_ff};
         quot_in = {quot_ff[DIV_NUM_W-2:0], 1'b1};
      end else begin
         rem_in  = shifted;
         quot_in = {quot_ff[DIV_NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= num;
         rem_ff  <= '0;
         den_ff  <= den;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

>>> rtl/core/dtwpe_datapath.sv
// Datapath: latched call values, sample ring, delay line, window scan and bound sum.
`timescale 1ns / 1ps
`default_nettype none
module dtwpe_datapath #(
   parameter int MAX_WINDOW = dtwpe_pkg::MAX_WINDOW_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire dtwpe_pkg::dtwpe_cmd_type               cmd,
   output dtwpe_pkg::dtwpe_status_type                 status,
   input  wire logic                                   req_first,
   input  wire logic signed [31:0]                     req_query_sample,
   input  wire logic signed [31:0]                     req_query_upper,
   input  wire logic signed [31:0]                     req_query_lower,
   input  wire logic signed [31:0]                     req_cand_sample,
   input  wire logic signed [31:0]                     req_cand_upper_raw,
   input  wire logic signed [31:0]                     req_cand_lower_raw,
   input  wire logic signed [31:0]                     req_cand_mean,
   input  wire logic [dtwpe_pkg::STD_W-1:0]            req_cand_std,
   input  wire logic [dtwpe_pkg::BOUND_W-1:0]          req_start_bound,
   input  wire logic [dtwpe_pkg::BOUND_W-1:0]          req_abandon_limit,
   input  wire logic                                   csr_valid,
   input  wire logic [dtwpe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [dtwpe_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [dtwpe_pkg::POS_W-1:0]                 rsp_position,
   output logic [dtwpe_pkg::BOUND_W-1:0]               rsp_local_term,
   output logic [dtwpe_pkg::BOUND_W-1:0]               rsp_running_bound,
   output logic                                        rsp_abandoned,
   output logic                                        rsp_done_res
);
   import dtwpe_pkg::*;

   localparam int RING_N  = 2 * MAX_WINDOW + 1;
   localparam int DLY_N   = MAX_WINDOW + 1;
   localparam int RING_AW = $clog2(RING_N);
   localparam int DLY_AW  = $clog2(DLY_N);
   localparam logic [RING_AW:0]     RING_N_L = (RING_AW + 1)'(RING_N);
   localparam logic [DLY_AW:0]      DLY_N_L  = (DLY_AW + 1)'(DLY_N);
   localparam logic [RING_AW-1:0]   RING_TOP = RING_AW'(RING_N - 1);
   localparam logic [DLY_AW-1:0]    DLY_TOP  = DLY_AW'(DLY_N - 1);
   localparam logic [CFG_W_W-1:0]   MAXW_L   = CFG_W_W'(MAX_WINDOW);
   localparam logic [CFG_W_W-1:0]   W_RST    = (WINDOW_RESET > MAXW_L) ? MAXW_L : WINDOW_RESET;
   localparam logic signed [31:0]   POS_SAT  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0]   NEG_SAT  = 32'sh8000_0000;
   localparam logic [DIV_NUM_W-1:0] POS_LIM  = DIV_NUM_W'(64'h7FFF_FFFF);
   localparam logic [DIV_NUM_W-1:0] NEG_LIM  = DIV_NUM_W'(64'h8000_0000);

   logic signed [31:0] ring_mem [RING_N];
   logic [95:0]        dly_mem  [DLY_N];

   logic [CFG_W_W-1:0] cfg_w_ff;
   logic [POS_W-1:0]   cfg_m_ff;
   logic signed [31:0] q_ff, uq_ff, lq_ff, x_ff, cu_ff, cl_ff;
   logic signed [31:0] mean_ff;
   logic [STD_W-1:0]   std_ff;
   logic [BOUND_W-1:0] limit_ff, bound_ff, term_ff;
   logic [CFG_W_W-1:0] w_ff;
   logic [POS_W-1:0]   m_ff, i_ff, cur_i_ff, j_ff, jhi_ff;
   logic               stopped_ff, first_el_ff, div_neg_ff;
   logic [RING_AW-1:0] ring_wp_ff, cur_ring_ff, ring_ra_ff, left_ff;
   logic [DLY_AW-1:0]  dly_wp_ff, cur_dly_ff, dly_ra_ff;
   logic signed [31:0] un_ff, ln_ff, up_ff, lo_ff, ring_rd_ff;
   logic [95:0]        dly_rd_ff;
   logic [63:0]        sq1_ff, sq2_ff;
   logic               rsp_valid_ff, rsp_abandoned_ff, rsp_done_ff;
   logic [POS_W-1:0]   rsp_position_ff;
   logic [BOUND_W-1:0] rsp_term_ff, rsp_bound_ff;

   logic [POS_W-1:0]   w16, jdiff, jlo_c, jhi_c, a_c, b_c, da_c, cnt_c, e_c;
   logic [POS_W:0]     bsum;
   logic [RING_AW:0]   ring_ra_in;
   logic [DLY_AW:0]    dly_ra_in;
   logic               need_norm;
   logic signed [31:0] p_c, raw_c, norm_c;
   logic signed [32:0] ndiff;
   logic [32:0]        nmag;
   logic [DIV_NUM_W-1:0] div_num, div_quot;
   logic               div_done;
   logic signed [31:0] x_v, uq_v, lq_v, m1a, m1b, m2a, m2b, op_a, op_b;
   logic               c1, c2, c3, c4;
   logic signed [32:0] mdiff;
   logic [31:0]        mmag;
   logic [63:0]        mprod, tdiff, bsum64;
   logic               run_done_c, rsp_free_c;

   // normalization divider operand
   always_comb begin
      raw_c   = cmd.div_lower ? cl_ff : cu_ff;
      ndiff   = 33'(raw_c) - 33'(mean_ff);
      nmag    = ndiff[32] ? 33'(-ndiff) : 33'(ndiff);
      div_num = {nmag[32:0], 16'b0};
   end

   dtwpe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (std_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      if (!div_neg_ff) begin
         norm_c = (div_quot > POS_LIM) ? POS_SAT : signed'(div_quot[31:0]);
      end else begin
         norm_c = (div_quot > NEG_LIM) ? NEG_SAT : signed'(32'(-div_quot[31:0]));
      end
   end

   // projection and window bookkeeping
   always_comb begin
      need_norm = (i_ff >= EDGE_POS) && (({1'b0, i_ff} + 17'(EDGE_POS)) < {1'b0, m_ff});
      if (need_norm && (q_ff > un_ff)) begin
         p_c = un_ff;
      end else if (need_norm && (q_ff < ln_ff)) begin
         p_c = ln_ff;
      end else begin
         p_c = q_ff;
      end
      w16   = POS_W'(w_ff);
      jdiff = i_ff - w16;
      jlo_c = (jdiff < EDGE_POS) ? EDGE_POS : jdiff;
      jhi_c = (i_ff == m_ff - 16'd1) ? (m_ff - TAIL_GAP) : jdiff;
      a_c   = (j_ff >= w16) ? (j_ff - w16) : '0;
      bsum  = {1'b0, j_ff} + {1'b0, w16};
      b_c   = (bsum > {1'b0, cur_i_ff}) ? cur_i_ff : bsum[POS_W-1:0];
      da_c  = cur_i_ff - a_c;
      cnt_c = b_c - a_c;
      e_c   = cur_i_ff - j_ff;
      ring_ra_in = {1'b0, cur_ring_ff} + RING_N_L - {1'b0, da_c[RING_AW-1:0]};
      if (ring_ra_in >= RING_N_L) ring_ra_in = ring_ra_in - RING_N_L;
      dly_ra_in = {1'b0, cur_dly_ff} + DLY_N_L - {1'b0, e_c[DLY_AW-1:0]};
      if (dly_ra_in >= DLY_N_L) dly_ra_in = dly_ra_in - DLY_N_L;
   end

   // term selection and the shared squarer
   always_comb begin
      x_v  = signed'(dly_rd_ff[95:64]);
      uq_v = signed'(dly_rd_ff[63:32]);
      lq_v = signed'(dly_rd_ff[31:0]);
      c1 = (x_v > up_ff) && (up_ff > uq_v);
      c2 = (x_v < lo_ff) && (lo_ff < lq_v);
      c3 = x_v > up_ff;
      c4 = x_v < lo_ff;
      m2a = x_v;
      m2b = x_v;
      if (c1) begin
         m1a = x_v;  m1b = uq_v;  m2a = up_ff;  m2b = uq_v;
      end else if (c2) begin
         m1a = x_v;  m1b = lq_v;  m2a = lo_ff;  m2b = lq_v;
      end else if (c3) begin
         m1a = x_v;  m1b = up_ff;
      end else if (c4) begin
         m1a = x_v;  m1b = lo_ff;
      end else begin
         m1a = x_v;  m1b = x_v;
      end
      op_a  = cmd.sq2 ? m2a : m1a;
      op_b  = cmd.sq2 ? m2b : m1b;
      mdiff = 33'(op_a) - 33'(op_b);
      mmag  = mdiff[32] ? 32'(-mdiff) : mdiff[31:0];
      mprod = 64'(mmag) * 64'(mmag);
      tdiff = sq1_ff - sq2_ff;
      bsum64 = {1'b0, bound_ff} + {1'b0, term_ff};
      run_done_c = (bound_ff > limit_ff) || (j_ff == m_ff - TAIL_GAP);
      rsp_free_c = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      status.skip      = stopped_ff || (i_ff >= m_ff);
      status.need_norm = need_norm;
      status.div_done  = div_done;
      status.emit_any  = (i_ff >= w16) && (jlo_c <= jhi_c);
      status.scan_last = (left_ff == '0);
      status.rsp_free  = rsp_free_c;
      status.run_done  = run_done_c;
      status.last_j    = (j_ff == jhi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff     <= WINDOW_RESET;
         cfg_m_ff     <= LENGTH_RESET;
         w_ff         <= W_RST;
         m_ff         <= LENGTH_RESET;
         mean_ff      <= '0;
         std_ff       <= STD_W'(1);
         limit_ff     <= '0;
         bound_ff     <= '0;
         i_ff         <= '0;
         stopped_ff   <= 1'b0;
         ring_wp_ff   <= '0;
         dly_wp_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_WINDOW: cfg_w_ff <= csr_data[CFG_W_W-1:0];
               CSR_LENGTH: cfg_m_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.load && req_first) begin
            mean_ff    <= req_cand_mean;
            std_ff     <= (req_cand_std == '0) ? STD_W'(1) : req_cand_std;
            bound_ff   <= req_start_bound;
            limit_ff   <= req_abandon_limit;
            w_ff       <= (cfg_w_ff > MAXW_L) ? MAXW_L : cfg_w_ff;
            m_ff       <= (cfg_m_ff < LENGTH_MIN) ? LENGTH_MIN : cfg_m_ff;
            i_ff       <= '0;
            stopped_ff <= 1'b0;
            ring_wp_ff <= '0;
            dly_wp_ff  <= '0;
         end
         if (cmd.write) begin
            i_ff       <= i_ff + 16'd1;
            ring_wp_ff <= (ring_wp_ff == RING_TOP) ? '0 : ring_wp_ff + 1'b1;
            dly_wp_ff  <= (dly_wp_ff == DLY_TOP) ? '0 : dly_wp_ff + 1'b1;
         end
         if (cmd.acc) begin
            bound_ff <= bsum64[63] ? BOUND_MAX : bsum64[BOUND_W-1:0];
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            stopped_ff   <= run_done_c;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_ff  <= req_query_sample;
         uq_ff <= req_query_upper;
         lq_ff <= req_query_lower;
         x_ff  <= req_cand_sample;
         cu_ff <= req_cand_upper_raw;
         cl_ff <= req_cand_lower_raw;
      end
      if (cmd.div_start) div_neg_ff <= ndiff[32];
      if (cmd.store_un) un_ff <= norm_c;
      if (cmd.store_ln) ln_ff <= norm_c;
      if (cmd.write) begin
         ring_mem[ring_wp_ff] <= p_c;
         dly_mem[dly_wp_ff]   <= {x_ff, uq_ff, lq_ff};
         cur_ring_ff          <= ring_wp_ff;
         cur_dly_ff           <= dly_wp_ff;
         cur_i_ff             <= i_ff;
         j_ff                 <= jlo_c;
         jhi_ff               <= jhi_c;
      end
      ring_rd_ff <= ring_mem[ring_ra_ff];
      dly_rd_ff  <= dly_mem[dly_ra_ff];
      if (cmd.scan_init) begin
         ring_ra_ff  <= ring_ra_in[RING_AW-1:0];
         dly_ra_ff   <= dly_ra_in[DLY_AW-1:0];
         left_ff     <= cnt_c[RING_AW-1:0];
         first_el_ff <= 1'b1;
      end
      if (cmd.scan_step) begin
         if (first_el_ff || (ring_rd_ff > up_ff)) up_ff <= ring_rd_ff;
         if (first_el_ff || (ring_rd_ff < lo_ff)) lo_ff <= ring_rd_ff;
         first_el_ff <= 1'b0;
         left_ff     <= left_ff - 1'b1;
         ring_ra_ff  <= (ring_ra_ff == RING_TOP) ? '0 : ring_ra_ff + 1'b1;
      end
      if (cmd.sq1) sq1_ff <= mprod;
      if (cmd.sq2) sq2_ff <= mprod;
      if (cmd.sum) term_ff <= tdiff[63] ? BOUND_MAX : tdiff[BOUND_W-1:0];
      if (cmd.emit) begin
         rsp_position_ff  <= j_ff;
         rsp_term_ff      <= term_ff;
         rsp_bound_ff     <= bound_ff;
         rsp_abandoned_ff <= bound_ff > limit_ff;
         rsp_done_ff      <= run_done_c;
         j_ff             <= j_ff + 16'd1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_local_term    = rsp_term_ff;
   assign rsp_running_bound = rsp_bound_ff;
   assign rsp_abandoned     = rsp_abandoned_ff;
   assign rsp_done_res      = rsp_done_ff;

endmodule
`default_nettype wire

>>> rtl/core/dtwpe_ctrl.sv
// Controller state machine sequencing load, normalization, scan and term output.
`timescale 1ns / 1ps
`default_nettype none
module dtwpe_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire dtwpe_pkg::dtwpe_status_type   status,
   output dtwpe_pkg::dtwpe_cmd_type           cmd
);
   import dtwpe_pkg::*;

   dtwpe_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.skip) state_in = ST_IDLE;
            else if (status.need_norm) state_in = ST_DIVU;
            else state_in = ST_WRITE;
         end
         ST_DIVU:      state_in = ST_DIVU_WAIT;
         ST_DIVU_WAIT: if (status.div_done) state_in = ST_DIVL;
         ST_DIVL:      state_in = ST_DIVL_WAIT;
         ST_DIVL_WAIT: if (status.div_done) state_in = ST_WRITE;
         ST_WRITE:     state_in = status.emit_any ? ST_SCAN_INIT : ST_IDLE;
         ST_SCAN_INIT: state_in = ST_SCAN_ADDR;
         ST_SCAN_ADDR: state_in = ST_SCAN_DATA;
         ST_SCAN_DATA: state_in = status.scan_last ? ST_SQ1 : ST_SCAN_ADDR;
         ST_SQ1:       state_in = ST_SQ2;
         ST_SQ2:       state_in = ST_SUM;
         ST_SUM:       state_in = ST_ACC;
         ST_ACC:       state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.rsp_free) begin
               if (status.run_done || status.last_j) state_in = ST_IDLE;
               else state_in = ST_SCAN_INIT;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIVU:      cmd.div_start = 1'b1;
         ST_DIVU_WAIT: cmd.store_un  = status.div_done;
         ST_DIVL: begin
            cmd.div_start = 1'b1;
            cmd.div_lower = 1'b1;
         end
         ST_DIVL_WAIT: cmd.store_ln  = status.div_done;
         ST_WRITE:     cmd.write     = 1'b1;
         ST_SCAN_INIT: cmd.scan_init = 1'b1;
         ST_SCAN_DATA: cmd.scan_step = 1'b1;
         ST_SQ1:       cmd.sq1       = 1'b1;
         ST_SQ2:       cmd.sq2       = 1'b1;
         ST_SUM:       cmd.sum       = 1'b1;
         ST_ACC:       cmd.acc       = 1'b1;
         ST_EMIT:      cmd.emit      = status.rsp_free;
         default: ;
      endcase
   end

endmodule
`default_nettype wire
